// ===== sv/acpu_pkg.sv =====
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and constants
// Status codes, opcodes and the controller/datapath command and status structures.
// ----------------------------------------------------------------------------
package acpu_pkg;

  localparam int unsigned MemWordsDefault = 1024;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_HALT = 3'd1,
    ST_MEM  = 3'd2,
    ST_DEV  = 3'd3,
    ST_INV  = 3'd4
  } status_t;

  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_HALT = 5'd1;
  localparam logic [4:0] OP_LDI  = 5'd2;
  localparam logic [4:0] OP_LD   = 5'd3;
  localparam logic [4:0] OP_LDX  = 5'd4;
  localparam logic [4:0] OP_ST   = 5'd5;
  localparam logic [4:0] OP_STX  = 5'd6;
  localparam logic [4:0] OP_TAX  = 5'd7;
  localparam logic [4:0] OP_TXA  = 5'd8;
  localparam logic [4:0] OP_INX  = 5'd9;
  localparam logic [4:0] OP_ADD  = 5'd10;
  localparam logic [4:0] OP_SUB  = 5'd11;
  localparam logic [4:0] OP_MUL  = 5'd12;
  localparam logic [4:0] OP_DIV  = 5'd13;
  localparam logic [4:0] OP_REM  = 5'd14;
  localparam logic [4:0] OP_NEG  = 5'd15;
  localparam logic [4:0] OP_JMP  = 5'd16;
  localparam logic [4:0] OP_JZ   = 5'd17;
  localparam logic [4:0] OP_JNZ  = 5'd18;
  localparam logic [4:0] OP_IN   = 5'd19;
  localparam logic [4:0] OP_OUT  = 5'd20;

  // Address source for a memory access.
  typedef enum logic [1:0] {
    AS_PC   = 2'd0,
    AS_PC1  = 2'd1,
    AS_OPND = 2'd2,
    AS_OPX  = 2'd3
  } addr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_wr;    // write load word
    logic      mem_rd;     // issue read at sel address
    logic      mem_wr;     // write A at sel address
    addr_sel_t sel;
    logic      cap_op;     // capture read data as opcode
    logic      cap_opnd;   // capture read data as operand
    logic      exec;       // register update for the current opcode
    logic      mul;        // A = A * val
    logic      div_start;  // start divide of A by val
    logic      div_done_wr;// write divider result to A
    logic      fault_addr; // record sel address as memory fault
  } acpu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       addr_bad;  // sel address outside memory
    logic [4:0] op_lo;
    logic       op_big;    // opcode above twenty
    logic       acc_zero;
    logic       val_zero;
    logic       div_busy;
  } acpu_stat_t;

endpackage

// ===== sv/acpu_div.sv =====
// ----------------------------------------------------------------------------
// acpu_div: iterative signed divider
// Restoring division, one quotient bit per cycle; truncating quotient and
// remainder with the sign of the dividend.
// ----------------------------------------------------------------------------
module acpu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] q_r, q_nxt;
  logic [32:0] r_r, r_nxt;
  logic [31:0] d_r, d_nxt;
  logic        qneg_r, qneg_nxt;
  logic        rneg_r, rneg_nxt;
  logic [32:0] trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    trial    = {r_r[31:0], q_r[31]} - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      q_nxt    = dividend[31] ? 32'(-dividend) : dividend;
      d_nxt    = divisor[31] ? 32'(-divisor) : divisor;
      r_nxt    = '0;
      qneg_nxt = dividend[31] ^ divisor[31];
      rneg_nxt = dividend[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        r_nxt = trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = {r_r[31:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    d_r    <= d_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign busy = busy_r;
  assign quot = qneg_r ? 32'(-q_r) : q_r;
  assign rem  = rneg_r ? 32'(-r_r[31:0]) : r_r[31:0];

endmodule

// ===== sv/acpu_dp.sv =====
// ----------------------------------------------------------------------------
// acpu_dp: datapath
// Architectural registers, word memory, address formation, ALU and divider.
// ----------------------------------------------------------------------------
module acpu_dp #(
  parameter int unsigned MEM_WORDS = acpu_pkg::MemWordsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  acpu_pkg::acpu_cmd_t cmd,
  input  logic [9:0]          load_addr,
  input  logic [31:0]         load_data,
  input  logic [31:0]         dev_in_value,
  input  logic                set_status,
  input  acpu_pkg::status_t   new_status,
  input  logic                set_dev_fault,
  input  logic                dev_fault_num,
  input  logic                pc_add1,
  input  logic                pc_add2,
  input  logic                pc_jump,
  output acpu_pkg::acpu_stat_t stat,
  output acpu_pkg::status_t   status,
  output logic [31:0]         pc,
  output logic [31:0]         acc,
  output logic [31:0]         xr,
  output logic [31:0]         fault_addr,
  output logic [1:0]          fault_dev
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rdata_r;
  logic [31:0] pc_r, acc_r, x_r, mfault_r, opnd_r;
  logic [4:0]  op_r, op_cur;
  logic [1:0]  dfault_r;
  acpu_pkg::status_t st_r;
  logic [31:0] addr;
  logic [31:0] load_addr_w;
  logic        addr_bad;
  logic        div_busy;
  logic [31:0] quot, rem;

  // The load address is widened so that it can be compared with any memory size.
  assign load_addr_w = {22'd0, load_addr};

  // During decode the opcode is still in the read register.
  assign op_cur = cmd.cap_op ? rdata_r[4:0] : op_r;

  always_comb begin
    case (cmd.sel)
      acpu_pkg::AS_PC:   addr = pc_r;
      acpu_pkg::AS_PC1:  addr = pc_r + 32'd1;
      acpu_pkg::AS_OPND: addr = opnd_r;
      acpu_pkg::AS_OPX:  addr = opnd_r + x_r;
      default:           addr = pc_r;
    endcase
    addr_bad = addr[31] || (addr >= 32'(MEM_WORDS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (load_addr_w < 32'(MEM_WORDS)))
      mem[load_addr_w[AW-1:0]] <= load_data;
    else if (cmd.mem_wr && !addr_bad)
      mem[addr[AW-1:0]] <= acc_r;
    if (cmd.mem_rd)
      rdata_r <= mem[addr[AW-1:0]];
  end

  acpu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .divisor  (rdata_r),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      acc_r    <= '0;
      x_r      <= '0;
      st_r     <= acpu_pkg::ST_OK;
      mfault_r <= '1;
      dfault_r <= '1;
    end else begin
      if (cmd.cap_op)   op_r   <= rdata_r[4:0];
      if (cmd.cap_opnd) opnd_r <= rdata_r;
      if (cmd.fault_addr) mfault_r <= addr;
      if (set_status) st_r <= new_status;
      if (set_dev_fault) dfault_r <= {1'b0, dev_fault_num};
      if (pc_jump)      pc_r <= opnd_r;
      else if (pc_add2) pc_r <= pc_r + 32'd2;
      else if (pc_add1) pc_r <= pc_r + 32'd1;
      if (cmd.mul) acc_r <= acc_r * rdata_r;
      if (cmd.div_done_wr)
        acc_r <= (op_r == acpu_pkg::OP_DIV) ? quot : rem;
      if (cmd.exec) begin
        case (op_cur)
          acpu_pkg::OP_LDI: acc_r <= opnd_r;
          acpu_pkg::OP_LD,
          acpu_pkg::OP_LDX: acc_r <= rdata_r;
          acpu_pkg::OP_TAX: x_r   <= acc_r;
          acpu_pkg::OP_TXA: acc_r <= x_r;
          acpu_pkg::OP_INX: x_r   <= x_r + 32'd1;
          acpu_pkg::OP_ADD: acc_r <= acc_r + rdata_r;
          acpu_pkg::OP_SUB: acc_r <= acc_r - rdata_r;
          acpu_pkg::OP_NEG: acc_r <= 32'd0 - acc_r;
          acpu_pkg::OP_IN:  acc_r <= dev_in_value;
          default: ;
        endcase
      end
    end
  end

  assign stat.addr_bad = addr_bad;
  assign stat.op_lo    = rdata_r[4:0];
  assign stat.op_big   = (rdata_r > 32'd20);
  assign stat.acc_zero = (acc_r == 32'd0);
  assign stat.val_zero = (rdata_r == 32'd0);
  assign stat.div_busy = div_busy;

  assign status     = st_r;
  assign pc         = pc_r;
  assign acc        = acc_r;
  assign xr         = x_r;
  assign fault_addr = mfault_r;
  assign fault_dev  = dfault_r;

endmodule

// ===== sv/acpu_ctrl.sv =====
// ----------------------------------------------------------------------------
// acpu_ctrl: instruction sequencer
// Walks fetch, operand read, data access and execute, then holds the result.
// ----------------------------------------------------------------------------
module acpu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic                 in_dev_in_ok,
  input  logic                 in_dev_out_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  acpu_pkg::status_t    status,
  input  acpu_pkg::acpu_stat_t stat,
  output acpu_pkg::acpu_cmd_t  cmd,
  output logic                 set_status,
  output acpu_pkg::status_t    new_status,
  output logic                 set_dev_fault,
  output logic                 dev_fault_num,
  output logic                 pc_add1,
  output logic                 pc_add2,
  output logic                 pc_jump,
  output logic                 dev_out_valid,
  output logic                 dev_in_taken
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DECODE, S_OPND, S_OPWAIT, S_DATA, S_DWAIT,
    S_DIVRUN, S_DIVWAIT, S_OUT
  } state_t;

  state_t     state_r;
  logic [4:0] op_r;
  logic       dok_in_r, dok_out_r;
  logic       dov_r, dit_r;

  always_comb begin
    cmd           = '0;
    set_status    = 1'b0;
    new_status    = acpu_pkg::ST_OK;
    set_dev_fault = 1'b0;
    dev_fault_num = 1'b0;
    pc_add1       = 1'b0;
    pc_add2       = 1'b0;
    pc_jump       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_req_type) cmd.load_wr = 1'b1;
      end
      S_FETCH: begin
        cmd.sel = acpu_pkg::AS_PC;
        if (stat.addr_bad) begin
          cmd.fault_addr = 1'b1;
          set_status = 1'b1;
          new_status = acpu_pkg::ST_MEM;
        end else begin
          cmd.mem_rd = 1'b1;
        end
      end
      S_DECODE: begin
        cmd.cap_op = 1'b1;
        if (stat.op_big) begin
          set_status = 1'b1;
          new_status = acpu_pkg::ST_INV;
        end else begin
          case (stat.op_lo)
            acpu_pkg::OP_NOP: pc_add1 = 1'b1;
            acpu_pkg::OP_HALT: begin
              pc_add1 = 1'b1;
              set_status = 1'b1;
              new_status = acpu_pkg::ST_HALT;
            end
            acpu_pkg::OP_TAX, acpu_pkg::OP_TXA, acpu_pkg::OP_INX,
            acpu_pkg::OP_NEG: begin
              pc_add1 = 1'b1;
              cmd.exec = 1'b1;
            end
            acpu_pkg::OP_IN: begin
              if (dok_in_r) begin
                pc_add2 = 1'b1;
                cmd.exec = 1'b1;
              end else begin
                set_dev_fault = 1'b1;
                set_status = 1'b1;
                new_status = acpu_pkg::ST_DEV;
              end
            end
            acpu_pkg::OP_OUT: begin
              if (dok_out_r) begin
                pc_add2 = 1'b1;
              end else begin
                set_dev_fault = 1'b1;
                dev_fault_num = 1'b1;
                set_status = 1'b1;
                new_status = acpu_pkg::ST_DEV;
              end
            end
            acpu_pkg::OP_JZ:  if (!stat.acc_zero) pc_add2 = 1'b1;
            acpu_pkg::OP_JNZ: if (stat.acc_zero) pc_add2 = 1'b1;
            default: ;
          endcase
        end
      end
      S_OPND: begin
        cmd.sel = acpu_pkg::AS_PC1;
        if (stat.addr_bad) begin
          cmd.fault_addr = 1'b1;
          set_status = 1'b1;
          new_status = acpu_pkg::ST_MEM;
        end else begin
          cmd.mem_rd = 1'b1;
        end
      end
      S_OPWAIT: begin
        cmd.cap_opnd = 1'b1;
      end
      S_DATA: begin
        cmd.sel = (op_r == acpu_pkg::OP_LDX || op_r == acpu_pkg::OP_STX) ?
                  acpu_pkg::AS_OPX : acpu_pkg::AS_OPND;
        case (op_r)
          acpu_pkg::OP_LDI: begin
            cmd.exec = 1'b1;
            pc_add2 = 1'b1;
          end
          acpu_pkg::OP_JMP, acpu_pkg::OP_JZ, acpu_pkg::OP_JNZ: pc_jump = 1'b1;
          default: begin
            if (stat.addr_bad) begin
              cmd.fault_addr = 1'b1;
              set_status = 1'b1;
              new_status = acpu_pkg::ST_MEM;
            end else if (op_r == acpu_pkg::OP_ST || op_r == acpu_pkg::OP_STX) begin
              cmd.mem_wr = 1'b1;
              pc_add2 = 1'b1;
            end else begin
              cmd.mem_rd = 1'b1;
            end
          end
        endcase
      end
      S_DWAIT: begin
        if (op_r == acpu_pkg::OP_MUL) begin
          cmd.mul = 1'b1;
          pc_add2 = 1'b1;
        end else if (op_r == acpu_pkg::OP_DIV || op_r == acpu_pkg::OP_REM) begin
          if (stat.val_zero) begin
            set_status = 1'b1;
            new_status = acpu_pkg::ST_INV;
          end else begin
            cmd.div_start = 1'b1;
          end
        end else begin
          cmd.exec = 1'b1;
          pc_add2 = 1'b1;
        end
      end
      S_DIVWAIT: begin
        if (!stat.div_busy) begin
          cmd.div_done_wr = 1'b1;
          pc_add2 = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= '0;
      dok_in_r  <= 1'b0;
      dok_out_r <= 1'b0;
      dov_r     <= 1'b0;
      dit_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dok_in_r  <= in_dev_in_ok;
            dok_out_r <= in_dev_out_ok;
            dov_r     <= 1'b0;
            dit_r     <= 1'b0;
            if (in_req_type && status == acpu_pkg::ST_OK) state_r <= S_FETCH;
            else state_r <= S_OUT;
          end
        end
        S_FETCH:  state_r <= stat.addr_bad ? S_OUT : S_DECODE;
        S_DECODE: begin
          op_r <= stat.op_lo;
          if (stat.op_big) begin
            state_r <= S_OUT;
          end else begin
            case (stat.op_lo)
              acpu_pkg::OP_NOP, acpu_pkg::OP_HALT, acpu_pkg::OP_TAX,
              acpu_pkg::OP_TXA, acpu_pkg::OP_INX, acpu_pkg::OP_NEG:
                state_r <= S_OUT;
              acpu_pkg::OP_IN: begin
                dit_r <= dok_in_r;
                state_r <= S_OUT;
              end
              acpu_pkg::OP_OUT: begin
                dov_r <= dok_out_r;
                state_r <= S_OUT;
              end
              acpu_pkg::OP_JZ:  state_r <= stat.acc_zero ? S_OPND : S_OUT;
              acpu_pkg::OP_JNZ: state_r <= stat.acc_zero ? S_OUT : S_OPND;
              default: state_r <= S_OPND;
            endcase
          end
        end
        S_OPND:   state_r <= stat.addr_bad ? S_OUT : S_OPWAIT;
        S_OPWAIT: state_r <= S_DATA;
        S_DATA: begin
          if (op_r == acpu_pkg::OP_LDI || op_r == acpu_pkg::OP_JMP ||
              op_r == acpu_pkg::OP_JZ || op_r == acpu_pkg::OP_JNZ ||
              op_r == acpu_pkg::OP_ST || op_r == acpu_pkg::OP_STX || stat.addr_bad)
            state_r <= S_OUT;
          else
            state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if ((op_r == acpu_pkg::OP_DIV || op_r == acpu_pkg::OP_REM) && !stat.val_zero)
            state_r <= S_DIVRUN;
          else
            state_r <= S_OUT;
        end
        S_DIVRUN:  state_r <= S_DIVWAIT;
        S_DIVWAIT: if (!stat.div_busy) state_r <= S_OUT;
        S_OUT:     if (out_ready) state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign dev_out_valid = dov_r;
  assign dev_in_taken  = dit_r;

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVRUN) |-> stat.div_busy) else $error("divider not running");
  a_one_pc_update: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({pc_add1, pc_add2, pc_jump}) <= 1) else $error("conflicting PC updates");
  a_single_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_wr && cmd.mem_wr)) else $error("two memory writes");
`endif

endmodule

// ===== sv/accumulator_cpu_step.sv =====
// A load word is written as it is accepted; a step is paced by the single memory
// port (fetch, operand, data access in turn), then executes.
// Divide and remainder then wait on the one-bit-per-cycle divider.
// Throughput: one word at a time; the next word is taken after the result leaves.
// Reset (rst_n low, synchronous): PC, A, X are 0, status ok, fault address
// and fault device are -1; the memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// accumulator_cpu_step: accumulator machine, one instruction per word
// Sequencer plus datapath with internal word memory and iterative divider.
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
  parameter int unsigned MEM_WORDS = acpu_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [9:0]  in_load_addr,
  input  logic [31:0] in_load_data,
  input  logic [31:0] in_dev_in_value,
  input  logic        in_dev_in_ok,
  input  logic        in_dev_out_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_prog_counter,
  output logic [31:0] out_accum,
  output logic [31:0] out_index_reg,
  output logic        out_dev_out_valid,
  output logic [31:0] out_dev_out_value,
  output logic        out_dev_in_taken,
  output logic [31:0] out_fault_addr,
  output logic [1:0]  out_fault_dev
);

  acpu_pkg::acpu_cmd_t  cmd;
  acpu_pkg::acpu_stat_t stat;
  acpu_pkg::status_t    status, new_status;
  logic set_status, set_dev_fault, dev_fault_num;
  logic pc_add1, pc_add2, pc_jump, dov, dit;
  logic [31:0] acc, dev_in_r;

  // The device input word is captured when a word is accepted, since the
  // instruction reads it later, in the decode state.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) dev_in_r <= in_dev_in_value;
  end

  acpu_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_dev_in_ok  (in_dev_in_ok),
    .in_dev_out_ok (in_dev_out_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .stat          (stat),
    .cmd           (cmd),
    .set_status    (set_status),
    .new_status    (new_status),
    .set_dev_fault (set_dev_fault),
    .dev_fault_num (dev_fault_num),
    .pc_add1       (pc_add1),
    .pc_add2       (pc_add2),
    .pc_jump       (pc_jump),
    .dev_out_valid (dov),
    .dev_in_taken  (dit)
  );

  acpu_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .load_addr     (in_load_addr),
    .load_data     (in_load_data),
    .dev_in_value  (dev_in_r),
    .set_status    (set_status),
    .new_status    (new_status),
    .set_dev_fault (set_dev_fault),
    .dev_fault_num (dev_fault_num),
    .pc_add1       (pc_add1),
    .pc_add2       (pc_add2),
    .pc_jump       (pc_jump),
    .stat          (stat),
    .status        (status),
    .pc            (out_prog_counter),
    .acc           (acc),
    .xr            (out_index_reg),
    .fault_addr    (out_fault_addr),
    .fault_dev     (out_fault_dev)
  );

  // Output device value is the accumulator, which an output step leaves as is.
  assign out_status        = status;
  assign out_accum         = acc;
  assign out_dev_out_valid = dov;
  assign out_dev_out_value = dov ? acc : 32'd0;
  assign out_dev_in_taken  = dit;

endmodule

// ===== tb/accumulator_cpu_step_tb.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_step_tb: self-checking bench for the accumulator machine
// A short table of load and step words runs first. The random program after it
// writes every opcode, operand and data word ahead of the step that uses it, so
// no unwritten word is ever read. The run ends in one randomly chosen fault or a halt.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MemWords = 1024;
  localparam int RandomWords = 1710;
  localparam int CycleLimit = 400000;
  localparam int LongHold = 300;
  localparam logic [31:0] MinInt = 32'h8000_0000;

  // One word on the input channel.
  typedef struct {
    logic        req;
    logic [9:0]  addr;
    logic [31:0] data;
    logic [31:0] din;
    logic        dok;
    logic        ook;
  } cpu_word_t;

  // One word on the result channel.
  typedef struct {
    acpu_pkg::status_t st;
    logic [31:0] pc;
    logic [31:0] acc;
    logic [31:0] x;
    logic        dov;
    logic [31:0] dval;
    logic        taken;
    logic [31:0] faddr;
    logic [1:0]  fdev;
  } cpu_result_t;

  // A row of the directed table: the word, and a typed-in result if there is one.
  typedef struct {
    cpu_word_t   w;
    bit          typed;
    cpu_result_t r;
  } table_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [9:0]  in_load_addr = '0;
  logic [31:0] in_load_data = '0;
  logic [31:0] in_dev_in_value = '0;
  logic        in_dev_in_ok = 1'b0;
  logic        in_dev_out_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_prog_counter;
  logic [31:0] out_accum;
  logic [31:0] out_index_reg;
  logic        out_dev_out_valid;
  logic [31:0] out_dev_out_value;
  logic        out_dev_in_taken;
  logic [31:0] out_fault_addr;
  logic [1:0]  out_fault_dev;

  accumulator_cpu_step dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow copy of the machine state, advanced when a word is accepted.
  acpu_pkg::status_t cpu_mode;
  logic [31:0] cpu_pc, cpu_acc, cpu_x, cpu_mem_fault;
  logic [1:0]  cpu_dev_fault;
  logic [31:0] cpu_mem [MemWords];

  cpu_result_t pending_results[$];
  table_row_t  directed_rows[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          steps_sent = 0;
  int          loads_sent = 0;
  int          results_seen = 0;
  bit [20:0]   ops_run = '0;
  int          send_idle_pct = 14;
  int          recv_idle_pct = 73;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Run-length guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit addr_valid(logic [31:0] a);
    return $signed(a) >= 0 && $signed(a) < MemWords;
  endfunction

  // A memory access outside the array latches the address and the memory error.
  function automatic bit mem_access(logic [31:0] a, bit wr, logic [31:0] wdata,
                                    output logic [31:0] rdata);
    rdata = '0;
    if (!addr_valid(a)) begin
      cpu_mem_fault = a;
      cpu_mode = acpu_pkg::ST_MEM;
      return 1'b0;
    end
    if (wr) cpu_mem[a[9:0]] = wdata;
    else rdata = cpu_mem[a[9:0]];
    return 1'b1;
  endfunction

  // Executes one instruction at PC against the shadow state.
  function automatic void run_instruction(cpu_word_t w, inout cpu_result_t r);
    logic [31:0] op, opnd, val, nxt;
    int          sa, sb, quo, rem;
    nxt = cpu_pc + 32'd1;
    if (!mem_access(cpu_pc, 1'b0, '0, op)) return;
    if (op > 32'd20) begin
      cpu_mode = acpu_pkg::ST_INV;
      return;
    end
    ops_run[op[4:0]] = 1'b1;
    case (op[4:0])
      acpu_pkg::OP_NOP: begin cpu_pc = nxt; return; end
      acpu_pkg::OP_HALT: begin cpu_pc = nxt; cpu_mode = acpu_pkg::ST_HALT; return; end
      acpu_pkg::OP_TAX: begin cpu_x = cpu_acc; cpu_pc = nxt; return; end
      acpu_pkg::OP_TXA: begin cpu_acc = cpu_x; cpu_pc = nxt; return; end
      acpu_pkg::OP_INX: begin cpu_x = cpu_x + 32'd1; cpu_pc = nxt; return; end
      acpu_pkg::OP_NEG: begin cpu_acc = 32'd0 - cpu_acc; cpu_pc = nxt; return; end
      acpu_pkg::OP_JZ: if (cpu_acc != 32'd0) begin cpu_pc = cpu_pc + 32'd2; return; end
      acpu_pkg::OP_JNZ: if (cpu_acc == 32'd0) begin cpu_pc = cpu_pc + 32'd2; return; end
      acpu_pkg::OP_IN: begin
        if (!w.dok) begin
          cpu_dev_fault = 2'd0;
          cpu_mode = acpu_pkg::ST_DEV;
          return;
        end
        cpu_acc = w.din;
        r.taken = 1'b1;
        cpu_pc = cpu_pc + 32'd2;
        return;
      end
      acpu_pkg::OP_OUT: begin
        if (!w.ook) begin
          cpu_dev_fault = 2'd1;
          cpu_mode = acpu_pkg::ST_DEV;
          return;
        end
        r.dov = 1'b1;
        r.dval = cpu_acc;
        cpu_pc = cpu_pc + 32'd2;
        return;
      end
      default: ;
    endcase
    // Everything left takes an operand word.
    if (!mem_access(nxt, 1'b0, '0, opnd)) return;
    case (op[4:0])
      acpu_pkg::OP_LDI: cpu_acc = opnd;
      acpu_pkg::OP_JMP, acpu_pkg::OP_JZ, acpu_pkg::OP_JNZ: begin
        cpu_pc = opnd;
        return;
      end
      acpu_pkg::OP_ST: if (!mem_access(opnd, 1'b1, cpu_acc, val)) return;
      acpu_pkg::OP_STX: if (!mem_access(opnd + cpu_x, 1'b1, cpu_acc, val)) return;
      acpu_pkg::OP_LDX: begin
        if (!mem_access(opnd + cpu_x, 1'b0, '0, val)) return;
        cpu_acc = val;
      end
      default: begin
        if (!mem_access(opnd, 1'b0, '0, val)) return;
        case (op[4:0])
          acpu_pkg::OP_LD: cpu_acc = val;
          acpu_pkg::OP_ADD: cpu_acc = cpu_acc + val;
          acpu_pkg::OP_SUB: cpu_acc = cpu_acc - val;
          acpu_pkg::OP_MUL: cpu_acc = cpu_acc * val;
          default: begin
            if (val == 32'd0) begin
              cpu_mode = acpu_pkg::ST_INV;
              return;
            end
            sa = $signed(cpu_acc);
            sb = $signed(val);
            // The most negative value over -1 wraps back onto itself.
            if (cpu_acc == MinInt && val == 32'hFFFF_FFFF) begin
              quo = sa;
              rem = 0;
            end else begin
              quo = sa / sb;
              rem = sa % sb;
            end
            cpu_acc = (op[4:0] == acpu_pkg::OP_DIV) ? quo : rem;
          end
        endcase
      end
    endcase
    cpu_pc = cpu_pc + 32'd2;
  endfunction

  // Expected result of one accepted word; also advances the shadow state.
  function automatic cpu_result_t machine_result(cpu_word_t w);
    cpu_result_t r;
    r.dov = 1'b0;
    r.dval = '0;
    r.taken = 1'b0;
    if (!w.req) cpu_mem[w.addr] = w.data;
    else if (cpu_mode == acpu_pkg::ST_OK) run_instruction(w, r);
    r.st = cpu_mode;
    r.pc = cpu_pc;
    r.acc = cpu_acc;
    r.x = cpu_x;
    r.faddr = cpu_mem_fault;
    r.fdev = cpu_dev_fault;
    return r;
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return MinInt;
      4: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic cpu_word_t load_word(logic [31:0] a, logic [31:0] d);
    cpu_word_t w;
    w.req = 1'b0;
    w.addr = a[9:0];
    w.data = d;
    w.din = $urandom;
    w.dok = 1'($urandom_range(0, 1));
    w.ook = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic cpu_word_t step_word(logic [31:0] din, logic dok, logic ook);
    cpu_word_t w;
    w = load_word($urandom_range(0, MemWords - 1), $urandom);
    w.req = 1'b1;
    w.din = din;
    w.dok = dok;
    w.ook = ook;
    return w;
  endfunction

  // Expected value for a table row whose result is obvious: status ok, no faults.
  function automatic cpu_result_t ok_result(logic [31:0] pc, logic [31:0] acc);
    cpu_result_t r;
    r.st = acpu_pkg::ST_OK;
    r.pc = pc;
    r.acc = acc;
    r.x = '0;
    r.dov = 1'b0;
    r.dval = '0;
    r.taken = 1'b0;
    r.faddr = 32'hFFFF_FFFF;
    r.fdev = 2'b11;
    return r;
  endfunction

  function automatic void add_row(cpu_word_t w, bit typed = 1'b0,
                                  cpu_result_t r = ok_result(0, 0));
    table_row_t row;
    row.w = w;
    row.typed = typed;
    row.r = r;
    directed_rows.push_back(row);
  endfunction

  // Offers one word, idling first at random, and records its expected result once
  // the handshake completes.
  task automatic send_word(cpu_word_t w, bit typed = 1'b0,
                           cpu_result_t r = ok_result(0, 0));
    cpu_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= w.req;
    in_load_addr <= w.addr;
    in_load_data <= w.data;
    in_dev_in_value <= w.din;
    in_dev_in_ok <= w.dok;
    in_dev_out_ok <= w.ook;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = machine_result(w);
    pending_results.push_back(typed ? r : predicted);
    words_sent++;
    if (w.req) steps_sent++;
    else loads_sent++;
  endtask

  task automatic send_load(logic [31:0] a, logic [31:0] d);
    send_word(load_word(a, d));
  endtask

  // One well-formed instruction: its data word, opcode and operand are loaded
  // first, then the step runs. Indexed forms pick the operand so that operand
  // plus X lands on the chosen word. Near the top of memory a jump pulls PC back.
  task automatic random_instruction();
    logic [31:0] op, opnd, target, dat;
    logic        dok, ook;
    target = $urandom_range(0, MemWords - 1);
    dat = edge_value();
    if (cpu_pc > 32'd1000) op = 32'(acpu_pkg::OP_JMP);
    else op = $urandom_range(0, 20);
    if (op[4:0] == acpu_pkg::OP_HALT) op = 32'(acpu_pkg::OP_NOP);
    if (op[4:0] == acpu_pkg::OP_DIV || op[4:0] == acpu_pkg::OP_REM) begin
      if (dat == 32'd0) dat = 32'd7;
      if ($urandom_range(0, 3) == 0) dat = 32'hFFFF_FFFF;
    end
    case (op[4:0])
      acpu_pkg::OP_LDI: opnd = edge_value();
      acpu_pkg::OP_LDX, acpu_pkg::OP_STX: opnd = target - cpu_x;
      acpu_pkg::OP_JMP, acpu_pkg::OP_JZ, acpu_pkg::OP_JNZ: opnd = $urandom_range(0, 1000);
      default: opnd = target;
    endcase
    if ($urandom_range(0, 7) == 0) send_load($urandom_range(0, MemWords - 1), $urandom);
    send_load(target, dat);
    send_load(cpu_pc, op);
    send_load(cpu_pc + 32'd1, opnd);
    dok = (op[4:0] == acpu_pkg::OP_IN) ? 1'b1 : 1'($urandom_range(0, 1));
    ook = (op[4:0] == acpu_pkg::OP_OUT) ? 1'b1 : 1'($urandom_range(0, 1));
    send_word(step_word(edge_value(), dok, ook));
  endtask

  // Ends the program with one fault or a halt, chosen at random.
  task automatic closing_fault();
    logic [31:0] opnd;
    opnd = $urandom_range(0, 1) ? 32'(MemWords) + $urandom_range(0, 5000) : MinInt | $urandom;
    case ($urandom_range(0, 7))
      0: begin
        send_load(cpu_pc, 32'(acpu_pkg::OP_HALT));
        send_word(step_word($urandom, 1'b1, 1'b1));
      end
      1: begin
        // Operand address outside memory.
        send_load(cpu_pc, 32'(acpu_pkg::OP_LD));
        send_load(cpu_pc + 32'd1, opnd);
        send_word(step_word($urandom, 1'b1, 1'b1));
      end
      2: begin
        // Indexed store that lands outside memory.
        send_load(cpu_pc, 32'(acpu_pkg::OP_STX));
        send_load(cpu_pc + 32'd1, opnd - cpu_x);
        send_word(step_word($urandom, 1'b1, 1'b1));
      end
      3: begin
        // Jump out of memory; the following fetch fails.
        send_load(cpu_pc, 32'(acpu_pkg::OP_JMP));
        send_load(cpu_pc + 32'd1, opnd);
        send_word(step_word($urandom, 1'b1, 1'b1));
        send_word(step_word($urandom, 1'b1, 1'b1));
      end
      4: begin
        send_load(cpu_pc, 32'(acpu_pkg::OP_IN));
        send_word(step_word($urandom, 1'b0, 1'b1));
      end
      5: begin
        send_load(cpu_pc, 32'(acpu_pkg::OP_OUT));
        send_word(step_word($urandom, 1'b1, 1'b0));
      end
      6: begin
        send_load(cpu_pc, $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(21, 255));
        send_word(step_word($urandom, 1'b1, 1'b1));
      end
      default: begin
        // Divide or remainder by zero.
        send_load(40, 32'h0);
        send_load(cpu_pc, $urandom_range(0, 1) ? 32'(acpu_pkg::OP_DIV)
                                                : 32'(acpu_pkg::OP_REM));
        send_load(cpu_pc + 32'd1, 32'd40);
        send_word(step_word($urandom, 1'b1, 1'b1));
      end
    endcase
    // Once stopped, steps change nothing and loads still go through.
    repeat (4) send_word(step_word($urandom, 1'b1, 1'b1));
    repeat (3) send_load($urandom_range(0, MemWords - 1), $urandom);
    send_word(step_word($urandom, 1'b1, 1'b1));
  endtask

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %h, got %h", name, expv, actv);
      fail_count++;
    end
  endtask

  // Result side: checks every accepted word and stalls at random, or for a long
  // stretch when the stimulus asks for one.
  always @(posedge clk) begin
    cpu_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = pending_results.pop_front();
          check_field("status", 32'(e.st), 32'(out_status));
          check_field("prog_counter", e.pc, out_prog_counter);
          check_field("accum", e.acc, out_accum);
          check_field("index_reg", e.x, out_index_reg);
          check_field("dev_out_valid", 32'(e.dov), 32'(out_dev_out_valid));
          check_field("dev_out_value", e.dval, out_dev_out_value);
          check_field("dev_in_taken", 32'(e.taken), 32'(out_dev_in_taken));
          check_field("fault_addr", e.faddr, out_fault_addr);
          check_field("fault_dev", 32'(e.fdev), 32'(out_fault_dev));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= LongHold;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cpu_mode = acpu_pkg::ST_OK;
    cpu_pc = '0;
    cpu_acc = '0;
    cpu_x = '0;
    cpu_mem_fault = 32'hFFFF_FFFF;
    cpu_dev_fault = 2'b11;

    // Directed table. A load first shows the reset state; then a short program
    // runs the most-negative divide and remainder by -1, device in and out, and
    // the register moves, ending in a jump into the random area.
    add_row(load_word(1023, 32'hFFFF_FFFF), 1'b1, ok_result(0, 0));
    add_row(load_word(0, 32'(acpu_pkg::OP_LDI)));
    add_row(load_word(1, MinInt));
    add_row(load_word(2, 32'(acpu_pkg::OP_DIV)));
    add_row(load_word(3, 32'd20));
    add_row(load_word(20, 32'hFFFF_FFFF));
    add_row(load_word(4, 32'(acpu_pkg::OP_REM)));
    add_row(load_word(5, 32'd20));
    add_row(load_word(6, 32'(acpu_pkg::OP_IN)));
    add_row(load_word(8, 32'(acpu_pkg::OP_OUT)));
    add_row(load_word(10, 32'(acpu_pkg::OP_NEG)));
    add_row(load_word(11, 32'(acpu_pkg::OP_TAX)));
    add_row(load_word(12, 32'(acpu_pkg::OP_INX)));
    add_row(load_word(13, 32'(acpu_pkg::OP_TXA)));
    add_row(load_word(14, 32'(acpu_pkg::OP_JMP)));
    add_row(load_word(15, 32'd40));
    add_row(step_word(32'h0, 1'b0, 1'b0), 1'b1, ok_result(2, MinInt));
    add_row(step_word(32'hFFFF_FFFF, 1'b1, 1'b1), 1'b1, ok_result(4, MinInt));
    add_row(step_word(32'h0, 1'b1, 1'b1), 1'b1, ok_result(6, 0));
    add_row(step_word(32'h7FFF_FFFF, 1'b1, 1'b0));
    add_row(step_word(32'h0, 1'b0, 1'b1));
    add_row(step_word(32'h0, 1'b0, 1'b0));
    add_row(step_word(32'h0, 1'b0, 1'b0));
    add_row(step_word(32'h0, 1'b0, 1'b0));
    add_row(step_word(32'h0, 1'b0, 1'b0));
    add_row(step_word(32'h0, 1'b0, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i].w, directed_rows[i].typed,
                                         directed_rows[i].r);

    while (words_sent < RandomWords) begin
      if (words_sent >= 600 && send_idle_pct == 14) begin
        // Sender waits for the block to drain, then the receiver stalls a long
        // while as the sender keeps offering words.
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        send_idle_pct = 73;
        recv_idle_pct = 14;
        hold_token++;
      end else if (words_sent >= 1200 && send_idle_pct == 73) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_token++;
      end
      random_instruction();
    end
    closing_fault();
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    $display("Covered %0d words (%0d steps, %0d loads), %0d results checked.",
             words_sent, steps_sent, loads_sent, results_seen);
    $display("Opcodes executed: %0d of 21, final status %0d.", $countones(ops_run), cpu_mode);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
